/* sv/pplp_pkg.sv */
// Shared types and constants of the packed pixel line packer.
// Used by the channel interfaces and by every module of the block; no dependencies.
`timescale 1ns / 1ps

package pplp_pkg;

   localparam int PixelWidth = 16;
   localparam int ByteWidth  = 8;
   localparam int PosWidth   = 16;
   localparam int MaxBytes   = 3;
   localparam int CsrWidth   = 16;

   // Packed sample width codes.
   typedef enum logic [1:0] {
      FMT_10 = 2'd0,
      FMT_12 = 2'd1,
      FMT_14 = 2'd2,
      FMT_16 = 2'd3
   } sample_format_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SAMPLE_FORMAT = 2'd0,
      CSR_SOURCE_BITS   = 2'd1,
      CSR_LINE_WIDTH    = 2'd2
   } csr_index_type;

   typedef struct packed {
      sample_format_type     sample_format;
      logic [4:0]            source_bits;
      logic [PosWidth-1:0]   line_width;
   } cfg_type;

   // The words caused by one pixel, ready for the output serialiser.
   typedef struct packed {
      logic [MaxBytes-1:0][ByteWidth-1:0] bytes;
      logic [1:0]                         count;
      logic                               line_end;
   } group_type;

endpackage

/* sv/pplp_req_if.sv */
// Pixel request channel: valid/ready handshake carrying one pixel per word.
// Depends on pplp_pkg for the pixel width.
`timescale 1ns / 1ps

interface pplp_req_if;
   logic                            valid;
   logic                            ready;
   logic [pplp_pkg::PixelWidth-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

/* sv/pplp_rsp_if.sv */
// Packed byte response channel: valid/ready handshake carrying one byte per word.
// Depends on pplp_pkg for the byte width.
`timescale 1ns / 1ps

interface pplp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pplp_pkg::ByteWidth-1:0] packed_byte;
   logic                           pixel_done;
   logic                           line_done;

   modport source (output valid, output packed_byte, output pixel_done,
                   output line_done, input ready);
   modport sink   (input valid, input packed_byte, input pixel_done,
                   input line_done, output ready);
endinterface

/* sv/pplp_pack_core.sv */
// Packing logic: aligns one pixel, splits it into bytes and keeps the line phase.
// Depends on pplp_pkg for the configuration and byte group types.
`timescale 1ns / 1ps

module pplp_pack_core (
   input  logic                            clock,
   input  logic                            reset,
   input  pplp_pkg::cfg_type               cfg,
   input  logic [pplp_pkg::PixelWidth-1:0] pixel,
   input  logic                            advance,
   output pplp_pkg::group_type             group
);

   logic [pplp_pkg::ByteWidth-1:0]  pending_byte_ff, pending_byte_in;
   logic [pplp_pkg::PosWidth-1:0]   pixel_position_ff, pixel_position_in;

   logic [4:0]                      sample_bits;
   logic [4:0]                      shift_amount;
   logic [pplp_pkg::PixelWidth-1:0] sample_mask;
   logic [pplp_pkg::PixelWidth-1:0] w;
   logic [1:0]                      phase;
   logic [pplp_pkg::ByteWidth-1:0]  pend;
   logic [pplp_pkg::MaxBytes-1:0][pplp_pkg::ByteWidth-1:0] bytes;
   logic [1:0]                      base_count;
   logic                            partial;
   logic                            last;
   logic                            flush;

   // Alignment: drop the excess source bits, then mask to the sample width.
   always_comb begin
      sample_bits  = 5'd10 + {2'b00, cfg.sample_format, 1'b0};
      shift_amount = (cfg.source_bits > sample_bits) ? (cfg.source_bits - sample_bits) : 5'd0;
      sample_mask  = 16'hFFFF >> (5'd16 - sample_bits);
      w            = (pixel >> shift_amount) & sample_mask;
   end

   assign phase = pixel_position_ff[1:0];

   always_comb begin
      bytes      = '0;
      base_count = 2'd1;
      partial    = 1'b1;
      pend       = pending_byte_ff;
      case (cfg.sample_format)
         pplp_pkg::FMT_16: begin
            bytes[0]   = w[7:0];
            bytes[1]   = w[15:8];
            base_count = 2'd2;
            partial    = 1'b0;
         end
         pplp_pkg::FMT_14: begin
            case (phase)
               2'd0: begin
                  bytes[0] = w[13:6];
                  pend     = {w[5:0], 2'b00};
               end
               2'd1: begin
                  bytes[0]   = {6'b0, w[13:12]} | pend;
                  bytes[1]   = w[11:4];
                  base_count = 2'd2;
                  pend       = {w[3:0], 4'b0000};
               end
               2'd2: begin
                  bytes[0]   = {4'b0, w[13:10]} | pend;
                  bytes[1]   = w[9:2];
                  base_count = 2'd2;
                  pend       = {w[1:0], 6'b000000};
               end
               default: begin
                  bytes[0]   = {2'b0, w[13:8]} | pend;
                  bytes[1]   = w[7:0];
                  base_count = 2'd2;
                  partial    = 1'b0;
               end
            endcase
         end
         pplp_pkg::FMT_12: begin
            if (phase[0]) begin
               bytes[0]   = {4'b0, w[11:8]} | pend;
               bytes[1]   = w[7:0];
               base_count = 2'd2;
               partial    = 1'b0;
            end else begin
               bytes[0] = w[11:4];
               pend     = {w[3:0], 4'b0000};
            end
         end
         pplp_pkg::FMT_10: begin
            case (phase)
               2'd0: begin
                  bytes[0] = w[9:2];
                  pend     = {w[1:0], 6'b000000};
               end
               2'd1: begin
                  bytes[0] = {2'b0, w[9:4]} | pend;
                  pend     = {w[3:0], 4'b0000};
               end
               2'd2: begin
                  bytes[0] = {4'b0, w[9:6]} | pend;
                  pend     = {w[5:0], 2'b00};
               end
               default: begin
                  bytes[0]   = {6'b0, w[9:8]} | pend;
                  bytes[1]   = w[7:0];
                  base_count = 2'd2;
                  partial    = 1'b0;
               end
            endcase
         end
         default: begin
            partial = 1'b0;
         end
      endcase

      if (!partial) begin
         pend = '0;
      end

      // The line ends here when the line width is at most the position plus one.
      last  = ({1'b0, pixel_position_ff} + 17'd1) >= {1'b0, cfg.line_width};
      flush = last && partial;
      if (flush) begin
         bytes[base_count] = pend;
      end

      group.bytes    = bytes;
      group.count    = base_count + {1'b0, flush};
      group.line_end = last;

      if (last) begin
         pending_byte_in   = '0;
         pixel_position_in = '0;
      end else begin
         pending_byte_in   = pend;
         pixel_position_in = pixel_position_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_byte_ff   <= '0;
         pixel_position_ff <= '0;
      end else if (advance) begin
         pending_byte_ff   <= pending_byte_in;
         pixel_position_ff <= pixel_position_in;
      end
   end

endmodule

/* sv/pplp_byte_emitter.sv */
// Result register and serialiser: holds one pixel's bytes and sends them one per word.
// Depends on pplp_pkg for the byte group type and on the pplp_rsp_if interface.
`timescale 1ns / 1ps

module pplp_byte_emitter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  pplp_pkg::group_type  group,
   output logic                 can_load,
   pplp_rsp_if.source           rsp_if
);

   logic                      valid_ff, valid_in;
   logic [1:0]                index_ff, index_in;
   pplp_pkg::group_type       group_ff;
   logic                      final_word;

   assign final_word = (index_ff == (group_ff.count - 2'd1));
   assign can_load   = !valid_ff || (rsp_if.ready && final_word);

   always_comb begin
      valid_in = valid_ff;
      index_in = index_ff;
      if (load) begin
         valid_in = 1'b1;
         index_in = 2'd0;
      end else if (valid_ff && rsp_if.ready) begin
         if (final_word) begin
            valid_in = 1'b0;
         end else begin
            index_in = index_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         group_ff <= group;
      end
   end

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.packed_byte = group_ff.bytes[index_ff];
   assign rsp_if.pixel_done  = final_word;
   assign rsp_if.line_done   = final_word && group_ff.line_end;

endmodule

/* sv/packed_pixel_line_packer_unit.sv */
// Top level of the packed pixel line packer: configuration registers, input register,
// packing logic and byte serialiser. Depends on pplp_pkg, pplp_req_if, pplp_rsp_if,
// pplp_pack_core and pplp_byte_emitter.
`timescale 1ns / 1ps

//  Channel   Direction  Word carries                          Handshake
//  req_if    in         pixel_value (16 bits)                 valid / ready
//  rsp_if    out        packed_byte, pixel_done, line_done    valid / ready
//  csr_*     in         register index and 16-bit data        write enable only
//
// A pixel is caught in the input register at the edge it is accepted. Once the result
// register can take them, it is packed and its one to three bytes are loaded into the
// result register, from which the first byte goes onto the response port. The result
// register sends one byte per cycle while rsp_if.ready is high; the single byte-wide
// output port sets that rate. A new pixel is taken while the previous one's last byte
// is being sent.
// Reset is synchronous and restores the default configuration (16-bit samples, 16
// source bits, one pixel per line) and the start of a line. A stall on the response
// side fills the result register and then the input register, after which
// req_if.ready drops.

module packed_pixel_line_packer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   pplp_req_if.sink                             req_if,
   pplp_rsp_if.source                           rsp_if,
   input  logic                                 csr_write_enable,
   input  logic [1:0]                           csr_index,
   input  logic [pplp_pkg::CsrWidth-1:0]        csr_write_data
);

   pplp_pkg::cfg_type               cfg_ff;
   logic                            in_valid_ff;
   logic [pplp_pkg::PixelWidth-1:0] in_pixel_ff;
   pplp_pkg::group_type             group;
   logic                            can_load;
   logic                            advance;

   // Configuration registers. Writes to the unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_format <= pplp_pkg::FMT_16;
         cfg_ff.source_bits   <= 5'd16;
         cfg_ff.line_width    <= 16'd1;
      end else if (csr_write_enable) begin
         case (pplp_pkg::csr_index_type'(csr_index))
            pplp_pkg::CSR_SAMPLE_FORMAT: begin
               cfg_ff.sample_format <= pplp_pkg::sample_format_type'(csr_write_data[1:0]);
            end
            pplp_pkg::CSR_SOURCE_BITS: begin
               cfg_ff.source_bits <= csr_write_data[4:0];
            end
            pplp_pkg::CSR_LINE_WIDTH: begin
               cfg_ff.line_width <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // The held pixel moves on whenever the result register can take its bytes.
   assign advance      = in_valid_ff && can_load;
   assign req_if.ready = !in_valid_ff || can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_pixel_ff <= req_if.pixel_value;
      end
   end

   pplp_pack_core u_pack_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .pixel   (in_pixel_ff),
      .advance (advance),
      .group   (group)
   );

   pplp_byte_emitter u_byte_emitter (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .group    (group),
      .can_load (can_load),
      .rsp_if   (rsp_if)
   );

`ifndef NO_ASSERTIONS
   // The end of a line is always the last byte of its pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.line_done |-> rsp_if.pixel_done)
      else $error("line_done without pixel_done");

   // Bytes of a packed pixel reach the result register in the cycle after it moves on.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_if.valid)
      else $error("packed pixel did not reach the result register");

   // A held pixel is not dropped while the result register is busy.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("held pixel lost");

   // A byte that is not the last of its pixel is always followed by another.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && !rsp_if.pixel_done |=> rsp_if.valid)
      else $error("pixel bytes cut short");
`endif

endmodule
